// ===== hw/rtl/keypad_pwm_duty_controller_macros.svh =====
// Assertion macros used by the keypad duty controller top level.
// Each macro expects clk and rst_n in scope at the place of use.
`ifndef KEYPAD_PWM_DUTY_CONTROLLER_MACROS_SVH
`define KEYPAD_PWM_DUTY_CONTROLLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/kpd_pkg.sv =====
// Shared types, constants and helpers for the keypad duty controller.
// Used by kpd_ctrl, kpd_scale and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package kpd_pkg;

  localparam int TIME_W = 32;
  localparam int NKEYS  = 4;

  typedef logic [TIME_W-1:0] time_t;

  localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [1:0] CFG_HOLD     = 2'd1;
  localparam logic [1:0] CFG_INTERVAL = 2'd2;
  localparam logic [1:0] CFG_PERIOD   = 2'd3;

  localparam logic [7:0]  DEBOUNCE_RST = 8'd20;
  localparam logic [11:0] HOLD_RST     = 12'd400;
  localparam logic [9:0]  INTERVAL_RST = 10'd50;
  localparam logic [15:0] PERIOD_RST   = 16'd99;

  localparam logic [6:0] DUTY_MAX    = 7'd100;
  localparam logic [6:0] DUTY_RST    = 7'd30;
  localparam logic [3:0] STEP_FINE   = 4'd1;
  localparam logic [3:0] STEP_COARSE = 4'd10;

  localparam logic [1:0] MODE_SELECT = 2'd0;
  localparam logic [1:0] MODE_STEP   = 2'd1;
  localparam logic [1:0] MODE_COARSE = 2'd2;
  localparam logic [1:0] MODE_SMOOTH = 2'd3;

  // Division by 100 as a multiply by ceil(2^30 / 100) and a shift; exact for
  // every product of a 7-bit duty and a 16-bit period.
  localparam int          PROD_W      = 23;
  localparam int          RECIP_W     = 24;
  localparam int          RECIP_SHIFT = 30;
  localparam logic [23:0] RECIP_100   = 24'd10737419;

  typedef enum logic [2:0] {
    PH_RELEASED = 3'b001,
    PH_PENDING  = 3'b010,
    PH_HELD     = 3'b100
  } kpd_phase_t;

  typedef enum logic [3:0] {
    MENU_SELECT = 4'b0001,
    MENU_STEP   = 4'b0010,
    MENU_COARSE = 4'b0100,
    MENU_SMOOTH = 4'b1000
  } kpd_menu_t;

  typedef struct packed {
    logic [6:0] duty;
    logic [1:0] mode;
    logic [3:0] step;
    logic       updated;
  } kpd_res_t;

  typedef struct packed {
    kpd_res_t    res;
    logic [15:0] period;
  } kpd_item_t;

  function automatic logic [1:0] mode_code(input kpd_menu_t menu);
    logic [1:0] code;
    case (menu)
      MENU_SELECT: code = MODE_SELECT;
      MENU_STEP:   code = MODE_STEP;
      MENU_COARSE: code = MODE_COARSE;
      MENU_SMOOTH: code = MODE_SMOOTH;
      default:     code = MODE_SELECT;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/kpd_ctrl.sv =====
// Key debounce, auto-repeat timing and menu state for one scan per beat.
// Holds all per-key and menu state; depends on kpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kpd_ctrl import kpd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic [NKEYS-1:0] keys_level,
  input  time_t            now,
  input  logic [7:0]       debounce_time,
  input  logic [11:0]      hold_lead,
  input  logic [9:0]       repeat_interval,
  output kpd_res_t         res
);

  kpd_phase_t       phase_r [NKEYS];
  time_t            press_r [NKEYS];
  time_t            repeat_r [NKEYS];
  logic [NKEYS-1:0] pend_r;
  kpd_menu_t        menu_r;
  logic             choice_r;
  logic [3:0]       step_r;
  logic [6:0]       duty_r;

  kpd_phase_t       phase_d [NKEYS];
  time_t            press_d [NKEYS];
  time_t            repeat_d [NKEYS];
  logic [NKEYS-1:0] pend_d;
  time_t            el_deb [NKEYS];
  time_t            el_hold [2];
  time_t            el_rep [2];
  logic [1:0]       fire;

  time_t            repeat_nxt [NKEYS];
  logic [NKEYS-1:0] pend_nxt;
  kpd_menu_t        menu_nxt;
  logic             choice_nxt;
  logic [3:0]       step_nxt;
  logic [6:0]       duty_nxt;
  logic             upd_nxt;
  logic [7:0]       duty_sum;

  always_comb begin
    for (int k = 0; k < NKEYS; k++) begin
      phase_d[k]  = phase_r[k];
      press_d[k]  = press_r[k];
      repeat_d[k] = repeat_r[k];
      pend_d[k]   = pend_r[k];
      el_deb[k]   = now - press_r[k];
      case (phase_r[k])
        PH_PENDING: begin
          if (!keys_level[k]) begin
            phase_d[k] = PH_RELEASED;
          end else if (el_deb[k] > TIME_W'(debounce_time)) begin
            phase_d[k]  = PH_HELD;
            pend_d[k]   = 1'b1;
            press_d[k]  = now;
            repeat_d[k] = now;
          end
        end
        PH_HELD: begin
          if (!keys_level[k]) begin
            phase_d[k] = PH_RELEASED;
            pend_d[k]  = 1'b0;
          end
        end
        default: begin
          if (keys_level[k]) begin
            press_d[k] = now;
            phase_d[k] = PH_PENDING;
          end
        end
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      el_hold[k] = now - press_d[k];
      el_rep[k]  = now - repeat_d[k];
      fire[k]    = (phase_d[k] == PH_HELD) && (el_hold[k] > TIME_W'(hold_lead)) &&
                   (el_rep[k] > TIME_W'(repeat_interval));
    end
  end

  always_comb begin
    for (int k = 0; k < NKEYS; k++) begin
      repeat_nxt[k] = repeat_d[k];
    end
    pend_nxt   = pend_d;
    menu_nxt   = menu_r;
    choice_nxt = choice_r;
    step_nxt   = step_r;
    duty_nxt   = duty_r;
    upd_nxt    = 1'b0;
    duty_sum   = {1'b0, duty_r} + {4'b0000, step_r};
    case (menu_r)
      MENU_SELECT: begin
        if (pend_nxt[0]) begin
          pend_nxt[0] = 1'b0;
          menu_nxt    = MENU_STEP;
          choice_nxt  = 1'b1;
          step_nxt    = STEP_COARSE;
        end
        if (pend_nxt[1]) begin
          pend_nxt[1] = 1'b0;
          menu_nxt    = MENU_SMOOTH;
        end
      end
      MENU_STEP: begin
        if (pend_nxt[2]) begin
          pend_nxt[2] = 1'b0;
          choice_nxt  = 1'b0;
          step_nxt    = STEP_FINE;
        end
        if (pend_nxt[3]) begin
          pend_nxt[3] = 1'b0;
          choice_nxt  = 1'b1;
          step_nxt    = STEP_COARSE;
        end
        if (pend_nxt[0]) begin
          pend_nxt[0] = 1'b0;
          step_nxt    = choice_nxt ? STEP_COARSE : STEP_FINE;
          menu_nxt    = MENU_COARSE;
        end
      end
      MENU_COARSE: begin
        if (pend_nxt[0]) begin
          pend_nxt[0] = 1'b0;
          if (duty_sum <= {1'b0, DUTY_MAX}) begin
            duty_nxt = duty_sum[6:0];
            upd_nxt  = 1'b1;
          end
        end
        if (pend_nxt[1]) begin
          pend_nxt[1] = 1'b0;
          duty_nxt    = (duty_nxt >= {3'b000, step_nxt}) ? duty_nxt - {3'b000, step_nxt}
                                                         : 7'd0;
          upd_nxt     = 1'b1;
        end
        if (fire[0]) begin
          repeat_nxt[0] = now;
          if (duty_nxt < DUTY_MAX) begin
            duty_nxt = duty_nxt + 7'd1;
          end
          upd_nxt = 1'b1;
        end
        if (fire[1]) begin
          repeat_nxt[1] = now;
          if (duty_nxt != 7'd0) begin
            duty_nxt = duty_nxt - 7'd1;
          end
          upd_nxt = 1'b1;
        end
        if (pend_nxt[2]) begin
          pend_nxt[2] = 1'b0;
          step_nxt    = STEP_FINE;
        end
        if (pend_nxt[3]) begin
          pend_nxt[3] = 1'b0;
          step_nxt    = STEP_COARSE;
        end
      end
      MENU_SMOOTH: begin
        if (fire[0]) begin
          repeat_nxt[0] = now;
          if (duty_nxt < DUTY_MAX) begin
            duty_nxt = duty_nxt + 7'd1;
          end
          upd_nxt = 1'b1;
        end
        if (fire[1]) begin
          repeat_nxt[1] = now;
          if (duty_nxt != 7'd0) begin
            duty_nxt = duty_nxt - 7'd1;
          end
          upd_nxt = 1'b1;
        end
        if (pend_nxt[2]) begin
          pend_nxt[2] = 1'b0;
          duty_nxt    = 7'd0;
          upd_nxt     = 1'b1;
        end
        if (pend_nxt[3]) begin
          pend_nxt[3] = 1'b0;
          duty_nxt    = DUTY_MAX;
          upd_nxt     = 1'b1;
        end
      end
      default: begin
        menu_nxt = MENU_SELECT;
      end
    endcase
    if (duty_nxt > DUTY_MAX) begin
      duty_nxt = DUTY_MAX;
    end
  end

  assign res.duty    = duty_nxt;
  assign res.mode    = mode_code(menu_nxt);
  assign res.step    = step_nxt;
  assign res.updated = upd_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NKEYS; k++) begin
        phase_r[k] <= PH_RELEASED;
      end
      pend_r   <= '0;
      menu_r   <= MENU_SELECT;
      choice_r <= 1'b0;
      step_r   <= STEP_COARSE;
      duty_r   <= DUTY_RST;
    end else if (load) begin
      for (int k = 0; k < NKEYS; k++) begin
        phase_r[k] <= phase_d[k];
      end
      pend_r   <= pend_nxt;
      menu_r   <= menu_nxt;
      choice_r <= choice_nxt;
      step_r   <= step_nxt;
      duty_r   <= duty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < NKEYS; k++) begin
        press_r[k]  <= press_d[k];
        repeat_r[k] <= repeat_nxt[k];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/kpd_scale.sv =====
// Two-stage pipeline that scales the duty into the PWM compare pair.
// Stage one forms duty times period, stage two divides by 100; uses kpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kpd_scale import kpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s_valid,
  input  kpd_item_t   s_item,
  output logic        s_stall,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_duty_percent,
  output logic [15:0] out_compare_main,
  output logic [15:0] out_compare_complement,
  output logic [1:0]  out_menu_mode,
  output logic [3:0]  out_coarse_step,
  output logic        out_duty_updated
);

  localparam int QUO_W = PROD_W + RECIP_W;

  logic              a_valid_r;
  kpd_item_t         a_item_r;
  logic [PROD_W-1:0] a_prod_r;
  logic              o_valid_r;
  kpd_item_t         o_item_r;
  logic [15:0]       o_cmp_r;
  logic [15:0]       o_cmpl_r;

  logic              adv_o;
  logic              take_a;
  logic [QUO_W-1:0]  quo;
  logic [15:0]       cmp_nxt;

  assign adv_o   = a_valid_r && (!o_valid_r || !out_stall);
  assign s_stall = a_valid_r && !adv_o;
  assign take_a  = s_valid && !s_stall;

  assign quo     = QUO_W'(a_prod_r) * QUO_W'(RECIP_100);
  assign cmp_nxt = quo[RECIP_SHIFT +: 16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (take_a) begin
        a_valid_r <= 1'b1;
      end else if (adv_o) begin
        a_valid_r <= 1'b0;
      end
      if (adv_o) begin
        o_valid_r <= 1'b1;
      end else if (!out_stall) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_a) begin
      a_item_r <= s_item;
      a_prod_r <= PROD_W'(s_item.res.duty) * PROD_W'(s_item.period);
    end
    if (adv_o) begin
      o_item_r <= a_item_r;
      o_cmp_r  <= cmp_nxt;
      o_cmpl_r <= a_item_r.period - cmp_nxt;
    end
  end

  assign out_valid              = o_valid_r;
  assign out_duty_percent       = o_item_r.res.duty;
  assign out_compare_main       = o_cmp_r;
  assign out_compare_complement = o_cmpl_r;
  assign out_menu_mode          = o_item_r.res.mode;
  assign out_coarse_step        = o_item_r.res.step;
  assign out_duty_updated       = o_item_r.res.updated;

endmodule

`default_nettype wire

// ===== hw/rtl/keypad_pwm_duty_controller.sv =====
// Path: an accepted scan is registered by the state update stage, then by the
// multiply stage and the divide-by-100 stage that drives the result beat.
// Throughput: one scan per cycle unless out_stall backs up the pipeline; the depth is
// set by the state update stage and the multiply and divide-by-100 scaling stages.
// Reset: synchronous, active low; keys released, menu in mode select, duty 30,
// step 10, registers at 20, 400, 50 and 99 ms/counts; the pipeline empties.
`timescale 1ns / 1ps
`default_nettype none
`include "keypad_pwm_duty_controller_macros.svh"

module keypad_pwm_duty_controller import kpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_keys_level,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_duty_percent,
  output logic [15:0] out_compare_main,
  output logic [15:0] out_compare_complement,
  output logic [1:0]  out_menu_mode,
  output logic [3:0]  out_coarse_step,
  output logic        out_duty_updated
);

  logic [7:0]  debounce_r;
  logic [11:0] hold_r;
  logic [9:0]  interval_r;
  logic [15:0] period_r;

  logic        load;
  kpd_res_t    res;
  logic        s1_valid_r;
  kpd_item_t   s1_item_r;
  logic        scale_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      hold_r     <= HOLD_RST;
      interval_r <= INTERVAL_RST;
      period_r   <= PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE: debounce_r <= cfg_wdata[7:0];
        CFG_HOLD:     hold_r     <= cfg_wdata[11:0];
        CFG_INTERVAL: interval_r <= cfg_wdata[9:0];
        CFG_PERIOD:   period_r   <= cfg_wdata;
        default:      period_r   <= period_r;
      endcase
    end
  end

  assign in_stall = s1_valid_r && scale_stall;
  assign load     = in_valid && !in_stall;

  kpd_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (load),
    .keys_level      (in_keys_level),
    .now             (time_t'(in_now_ms[TIME_W-1:0])),
    .debounce_time   (debounce_r),
    .hold_lead       (hold_r),
    .repeat_interval (interval_r),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (load) begin
      s1_valid_r <= 1'b1;
    end else if (!scale_stall) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_item_r.res    <= res;
      s1_item_r.period <= period_r;
    end
  end

  kpd_scale u_scale (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .s_valid                (s1_valid_r),
    .s_item                 (s1_item_r),
    .s_stall                (scale_stall),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_duty_percent       (out_duty_percent),
    .out_compare_main       (out_compare_main),
    .out_compare_complement (out_compare_complement),
    .out_menu_mode          (out_menu_mode),
    .out_coarse_step        (out_coarse_step),
    .out_duty_updated       (out_duty_updated)
  );

  `KPD_ASSERT_NOW(a_empty_no_stall, !out_valid, !in_stall, "input stalled with empty output")
  `KPD_ASSERT_NOW(a_duty_range, out_valid, out_duty_percent <= DUTY_MAX, "duty above 100")
  `KPD_ASSERT_NOW(a_upd_run_mode, out_valid && out_duty_updated, (out_menu_mode == MODE_COARSE || out_menu_mode == MODE_SMOOTH), "refresh outside run modes")
  `KPD_ASSERT_NEXT(a_load_fills, load, s1_valid_r, "accepted scan lost at first stage")

endmodule

`default_nettype wire
